>>> rtl/u2l_pkg.sv
// ----------------------------------------------------------------------------
// u2l_pkg
// Shared types and constants for the UTF-8 to Latin-1 telnet passthrough.
// ----------------------------------------------------------------------------
package u2l_pkg;

  localparam logic [7:0] IAC_BYTE   = 8'hff;
  localparam logic [7:0] BAD_CHAR   = 8'h3f;
  localparam logic [7:0] ASCII_LIM  = 8'h80;
  localparam logic [7:0] LATIN_LOW  = 8'ha0;
  localparam logic [7:0] OPT_CMD_LO = 8'hfb;
  localparam logic [7:0] OPT_CMD_HI = 8'hfe;

  localparam int QUEUE_DEPTH = 2;

  // Decode mode, one-hot.
  typedef enum logic [3:0] {
    MODE_TEXT = 4'b0001,
    MODE_CONT = 4'b0010,
    MODE_IAC  = 4'b0100,
    MODE_OPT  = 4'b1000
  } mode_t;

  // One queued request: the final byte always sits in last_byte; a two-byte
  // request carries its leading byte in first_byte.
  typedef struct packed {
    logic       two;
    logic [7:0] first_byte;
    logic [7:0] last_byte;
  } req_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic valid;
    req_t req;
  } head_t;

endpackage

>>> rtl/u2l_front.sv
// ----------------------------------------------------------------------------
// u2l_front
// Accepts raw bytes, runs the UTF-8 / telnet decode state and pushes requests.
// ----------------------------------------------------------------------------
module u2l_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          full,
  output logic          accept,
  output logic          push,
  output u2l_pkg::req_t push_req
);

  u2l_pkg::mode_t mode, mode_next;
  logic           resume, resume_next;
  logic [1:0]     bytes_left, bytes_left_next;
  logic [20:0]    code_accum, code_accum_next;

  logic [1:0]     left_dec;
  logic [20:0]    cont_bits;
  logic [20:0]    accum_new;
  u2l_pkg::mode_t resume_mode;

  assign accept = in_valid && !full;

  always_comb begin
    left_dec = (bytes_left == 2'd0) ? 2'd0 : bytes_left - 2'd1;
    case (left_dec)
      2'd0:    cont_bits = {15'd0, in_byte[5:0]};
      2'd1:    cont_bits = {9'd0, in_byte[5:0], 6'd0};
      2'd2:    cont_bits = {3'd0, in_byte[5:0], 12'd0};
      default: cont_bits = {in_byte[2:0], 18'd0};
    endcase
    accum_new   = code_accum | cont_bits;
    resume_mode = resume ? u2l_pkg::MODE_CONT : u2l_pkg::MODE_TEXT;
  end

  always_comb begin
    mode_next       = mode;
    resume_next     = resume;
    bytes_left_next = bytes_left;
    code_accum_next = code_accum;
    push            = 1'b0;
    push_req        = '0;
    if (in_byte == u2l_pkg::IAC_BYTE &&
        (mode == u2l_pkg::MODE_TEXT || mode == u2l_pkg::MODE_CONT)) begin
      resume_next = (mode == u2l_pkg::MODE_CONT);
      mode_next   = u2l_pkg::MODE_IAC;
    end else begin
      case (mode)
        u2l_pkg::MODE_TEXT: begin
          if (in_byte < u2l_pkg::ASCII_LIM) begin
            push               = 1'b1;
            push_req.last_byte = in_byte;
          end else if (in_byte[7:5] == 3'b110) begin
            mode_next       = u2l_pkg::MODE_CONT;
            bytes_left_next = 2'd1;
            code_accum_next = {10'd0, in_byte[4:0], 6'd0};
          end else if (in_byte[7:4] == 4'b1110) begin
            mode_next       = u2l_pkg::MODE_CONT;
            bytes_left_next = 2'd2;
            code_accum_next = {5'd0, in_byte[3:0], 12'd0};
          end else if (in_byte[7:3] == 5'b11110) begin
            mode_next       = u2l_pkg::MODE_CONT;
            bytes_left_next = 2'd3;
            code_accum_next = {in_byte[2:0], 18'd0};
          end else begin
            push               = 1'b1;
            push_req.last_byte = u2l_pkg::BAD_CHAR;
          end
        end
        u2l_pkg::MODE_CONT: begin
          if (in_byte[7:6] != 2'b10) begin
            push               = 1'b1;
            push_req.last_byte = u2l_pkg::BAD_CHAR;
            code_accum_next    = '0;
            mode_next          = u2l_pkg::MODE_TEXT;
          end else if (left_dec == 2'd0) begin
            push = 1'b1;
            if (accum_new[20:8] == 13'd0 && accum_new[7:0] >= u2l_pkg::LATIN_LOW) begin
              push_req.last_byte = accum_new[7:0];
            end else begin
              push_req.last_byte = u2l_pkg::BAD_CHAR;
            end
            bytes_left_next = 2'd0;
            code_accum_next = '0;
            mode_next       = u2l_pkg::MODE_TEXT;
          end else begin
            bytes_left_next = left_dec;
            code_accum_next = accum_new;
          end
        end
        u2l_pkg::MODE_IAC: begin
          push = 1'b1;
          if (in_byte == u2l_pkg::IAC_BYTE) begin
            push_req.last_byte = u2l_pkg::BAD_CHAR;
            mode_next          = resume_mode;
          end else begin
            push_req.two        = 1'b1;
            push_req.first_byte = u2l_pkg::IAC_BYTE;
            push_req.last_byte  = in_byte;
            if (in_byte inside {[u2l_pkg::OPT_CMD_LO:u2l_pkg::OPT_CMD_HI]}) begin
              mode_next = u2l_pkg::MODE_OPT;
            end else begin
              mode_next = resume_mode;
            end
          end
        end
        u2l_pkg::MODE_OPT: begin
          push               = 1'b1;
          push_req.last_byte = in_byte;
          mode_next          = resume_mode;
        end
        default: begin
          mode_next = u2l_pkg::MODE_TEXT;
        end
      endcase
    end
    if (!accept) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= u2l_pkg::MODE_TEXT;
      resume     <= 1'b0;
      bytes_left <= 2'd0;
      code_accum <= '0;
    end else if (accept) begin
      mode       <= mode_next;
      resume     <= resume_next;
      bytes_left <= bytes_left_next;
      code_accum <= code_accum_next;
    end
  end

endmodule

>>> rtl/u2l_queue.sv
// ----------------------------------------------------------------------------
// u2l_queue
// Two-entry request queue between the decode front end and the output stage.
// ----------------------------------------------------------------------------
module u2l_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  u2l_pkg::req_t  push_req,
  input  logic           pop,
  output logic           full,
  output u2l_pkg::head_t head
);

  localparam int PtrW = $clog2(u2l_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(u2l_pkg::QUEUE_DEPTH + 1);

  u2l_pkg::req_t entries [u2l_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntW'(u2l_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.req   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(u2l_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(u2l_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/u2l_back.sv
// ----------------------------------------------------------------------------
// u2l_back
// Output stage: splits queued requests into result bytes in an output register.
// ----------------------------------------------------------------------------
module u2l_back (
  input  logic           clk,
  input  logic           rst,
  input  u2l_pkg::head_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           last
);

  logic load;
  logic phase;
  logic lead_half;

  assign load      = !out_valid || !out_stall;
  assign lead_half = head.req.two && !phase;
  assign pop       = load && head.valid && !lead_half;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= head.valid;
      if (head.valid) begin
        phase <= lead_half;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head.valid) begin
      out_byte <= lead_half ? head.req.first_byte : head.req.last_byte;
      last     <= !lead_half;
    end
  end

endmodule

>>> rtl/utf8_to_latin1_telnet_passthrough.sv
// ----------------------------------------------------------------------------
// utf8_to_latin1_telnet_passthrough
// UTF-8 to ISO-8859-1 byte converter with TELNET command passthrough.
// ----------------------------------------------------------------------------
// Throughput: one input byte per cycle while the request queue is not full; a
//   byte that yields two results (IAC plus command) holds the output register
//   for both results in turn.
// Input stall is the queue full flag of the two-entry request queue.
// Reset (rst, synchronous): decode state to plain text, queue empty,
//   output invalid.
// ----------------------------------------------------------------------------
module utf8_to_latin1_telnet_passthrough (
  input  logic       clk,
  input  logic       rst,
  // Raw byte channel.
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  // Converted byte channel.
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last
);

  logic           accept;
  logic           push;
  logic           pop;
  logic           full;
  u2l_pkg::req_t  push_req;
  u2l_pkg::head_t head;

  // Stall the source only while the request queue is full; the output side
  // is decoupled through the queue, so a stalled result never blocks decode
  // until the queue backs up.
  assign in_stall = full;

  // Front end: decode each accepted byte and push zero or one request.
  // Bytes that only advance the decoder (lead bytes, IAC) push nothing.
  u2l_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .full     (full),
    .accept   (accept),
    .push     (push),
    .push_req (push_req)
  );

  // Request queue: hold decoded requests until the output stage drains them.
  u2l_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .full     (full),
    .head     (head)
  );

  // Back end: emit one byte per cycle while not stalled, two bytes for an IAC
  // command request, and flag the final byte of each request with last.
  u2l_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule
